// ===== rtl/sws_pkg.sv =====
// Shared types, constants and decode helpers for the stopwatch display block.
// No dependencies; compiled first.
`default_nettype none

package sws_pkg;

  localparam int unsigned COUNT_W = 10;

  // Count wraps from MAX_COUNT to zero (kept within 0..999 so three digits suffice).
  localparam logic [COUNT_W-1:0] MAX_COUNT = 10'd999;

  localparam logic [7:0] SEG_DP  = 8'h80;
  localparam logic [6:0] SEG_BAD = 7'h40;

  localparam logic [2:0] EN_NONE = 3'b111;
  localparam logic [2:0] EN_HUND = 3'b110;
  localparam logic [2:0] EN_TENS = 3'b101;
  localparam logic [2:0] EN_ONES = 3'b011;

  typedef enum logic [1:0] {
    KIND_SCAN    = 2'd0,
    KIND_COUNT   = 2'd1,
    KIND_BUTTON  = 2'd2,
    KIND_RESTORE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAGE_HUND = 2'd0,
    STAGE_TENS = 2'd1,
    STAGE_ONES = 2'd2
  } stage_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] digit_enable_n;
  } disp_t;

  // Floor of x / 10 for any 10-bit x, by reciprocal multiply (exact below 1029).
  function automatic logic [6:0] div10(input logic [COUNT_W-1:0] x);
    logic [17:0] prod;
    prod = {8'd0, x} * 18'd205;
    return prod[17:11];
  endfunction

  // Floor of x / 100, exact for x up to 999.
  function automatic logic [3:0] div100(input logic [COUNT_W-1:0] x);
    logic [15:0] prod;
    prod = {6'd0, x} * 16'd41;
    return prod[15:12];
  endfunction

  function automatic logic [6:0] seg_decode(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = SEG_BAD;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sws_if.sv =====
// Valid/ready channel interfaces for the stopwatch: input items and result items.
// Depends on sws_pkg.
`default_nettype none

interface sws_item_if;
  import sws_pkg::*;
  logic                 valid;
  logic                 ready;
  kind_t                kind;
  logic                 start_level;
  logic                 clear_level;
  logic [COUNT_W-1:0]   restore_value;

  modport source (output valid, kind, start_level, clear_level, restore_value, input ready);
  modport sink   (input valid, kind, start_level, clear_level, restore_value, output ready);
endinterface

interface sws_result_if;
  import sws_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           segments;
  logic [2:0]           digit_enable_n;
  logic                 running;
  logic [COUNT_W-1:0]   current_count;
  logic                 save_request;
  logic [COUNT_W-1:0]   save_value;

  modport source (output valid, segments, digit_enable_n, running, current_count,
                  save_request, save_value, input ready);
  modport sink   (input valid, segments, digit_enable_n, running, current_count,
                  save_request, save_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/sws_disp.sv =====
// Digit split and seven-segment decode for one scan stage of the display.
// Depends on sws_pkg.
`default_nettype none

module sws_disp (
  input  wire logic [sws_pkg::COUNT_W-1:0] count,
  input  wire logic [1:0]                  stage,
  output sws_pkg::disp_t                   disp
);
  import sws_pkg::*;

  logic [6:0]         q10;
  logic [3:0]         hund;
  logic [6:0]         tens_full;
  logic [COUNT_W-1:0] ones_full;
  logic [3:0]         tens;
  logic [3:0]         ones;

  assign q10       = div10(count);
  assign hund      = div100(count);
  assign tens_full = q10 - ({3'd0, hund} * 7'd10);
  assign ones_full = count - ({3'd0, q10} * 10'd10);
  assign tens      = tens_full[3:0];
  assign ones      = ones_full[3:0];

  always_comb begin
    case (stage)
      STAGE_TENS: begin
        disp.segments       = SEG_DP | {1'b0, seg_decode(tens)};
        disp.digit_enable_n = EN_TENS;
      end
      STAGE_ONES: begin
        disp.segments       = {1'b0, seg_decode(ones)};
        disp.digit_enable_n = EN_ONES;
      end
      default: begin
        // out-of-rotation stage shows hundreds like stage 0
        disp.segments       = {1'b0, seg_decode(hund)};
        disp.digit_enable_n = EN_HUND;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/stopwatch_seven_segment_scan.sv =====
// Top level of the stopwatch with multiplexed three-digit display.
// Depends on sws_pkg, sws_if (interfaces) and sws_disp.
//
//   channel  | dir | fields
//   ---------+-----+-----------------------------------------------------------
//   item     | in  | kind, start_level, clear_level, restore_value
//   result   | out | segments, digit_enable_n, running, current_count,
//            |     | save_request, save_value
//
// One item per cycle sustained while results are taken; an item passes through the
// input register, then the result register, with state updated in between, before
// its result is on the output.
// Synchronous active-high reset: count, saved copy, stage and flags to zero.
// A stalled result holds in its register; the input register keeps taking items
// as long as it is empty, or the result register is free or drains in the same cycle.
`default_nettype none

module stopwatch_seven_segment_scan (
  input  wire logic  clk,
  input  wire logic  rst,
  sws_item_if.sink   item,
  sws_result_if.source result
);
  import sws_pkg::*;

  // input register
  logic               in_v;
  kind_t              in_kind;
  logic               in_start;
  logic               in_clear;
  logic [COUNT_W-1:0] in_restore;

  // block state
  logic [COUNT_W-1:0] tick_count, tick_count_next;
  logic [COUNT_W-1:0] saved_count, saved_count_next;
  logic [1:0]         scan_stage, scan_stage_next;
  logic               run_flag, run_flag_next;
  logic               button_held, button_held_next;

  // result register
  logic               res_v;
  disp_t              res_disp;
  logic               res_running;
  logic [COUNT_W-1:0] res_count;
  logic               res_save;
  logic [COUNT_W-1:0] res_save_val;

  logic               advance;
  disp_t              disp;
  disp_t              disp_next;
  logic               save_next;
  logic [COUNT_W-1:0] save_val_next;
  logic [COUNT_W-1:0] cnt_inc;
  logic [6:0]         inc_q10;
  logic [COUNT_W-1:0] inc_rem;
  logic [COUNT_W-1:0] restore_sat;

  assign advance    = in_v && (!res_v || result.ready);
  assign item.ready = !in_v || !res_v || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (item.ready) begin
      in_v <= item.valid;
    end
    if (item.valid && item.ready) begin
      in_kind    <= item.kind;
      in_start   <= item.start_level;
      in_clear   <= item.clear_level;
      in_restore <= item.restore_value;
    end
  end

  sws_disp u_disp (
    .count (tick_count),
    .stage (scan_stage),
    .disp  (disp)
  );

  assign cnt_inc     = !run_flag ? tick_count :
                       (tick_count >= MAX_COUNT) ? '0 : tick_count + 10'd1;
  assign inc_q10     = div10(cnt_inc);
  assign inc_rem     = cnt_inc - ({3'd0, inc_q10} * 10'd10);
  assign restore_sat = (in_restore > MAX_COUNT) ? MAX_COUNT : in_restore;

  always_comb begin
    tick_count_next  = tick_count;
    saved_count_next = saved_count;
    scan_stage_next  = scan_stage;
    run_flag_next    = run_flag;
    button_held_next = button_held;
    disp_next        = '{segments: 8'd0, digit_enable_n: EN_NONE};
    save_next        = 1'b0;
    save_val_next    = '0;
    case (in_kind)
      KIND_SCAN: begin
        disp_next = disp;
        case (scan_stage)
          STAGE_TENS: scan_stage_next = STAGE_ONES;
          STAGE_ONES: scan_stage_next = STAGE_HUND;
          default:    scan_stage_next = STAGE_TENS;
        endcase
      end
      KIND_COUNT: begin
        tick_count_next = cnt_inc;
        // save at each multiple of ten not yet persisted
        if (inc_rem == '0 && cnt_inc != saved_count) begin
          save_next        = 1'b1;
          save_val_next    = cnt_inc;
          saved_count_next = cnt_inc;
        end
      end
      KIND_BUTTON: begin
        if (in_start && !button_held) begin
          button_held_next = 1'b1;
          run_flag_next    = !run_flag;
        end else if (!in_start) begin
          button_held_next = 1'b0;
        end
        if (in_clear && tick_count != '0) begin
          tick_count_next  = '0;
          saved_count_next = '0;
          save_next        = 1'b1;
        end
      end
      default: begin
        tick_count_next  = restore_sat;
        saved_count_next = restore_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      saved_count <= '0;
      scan_stage  <= STAGE_HUND;
      run_flag    <= 1'b0;
      button_held <= 1'b0;
      res_v       <= 1'b0;
    end else begin
      if (advance) begin
        tick_count  <= tick_count_next;
        saved_count <= saved_count_next;
        scan_stage  <= scan_stage_next;
        run_flag    <= run_flag_next;
        button_held <= button_held_next;
        res_v       <= 1'b1;
      end else if (result.ready) begin
        res_v <= 1'b0;
      end
    end
    if (advance) begin
      res_disp     <= disp_next;
      res_running  <= run_flag_next;
      res_count    <= tick_count_next;
      res_save     <= save_next;
      res_save_val <= save_val_next;
    end
  end

  assign result.valid          = res_v;
  assign result.segments       = res_disp.segments;
  assign result.digit_enable_n = res_disp.digit_enable_n;
  assign result.running        = res_running;
  assign result.current_count  = res_count;
  assign result.save_request   = res_save;
  assign result.save_value     = res_save_val;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    tick_count <= MAX_COUNT)
    else $error("count beyond wrap limit");

  a_stage_rot: assert property (@(posedge clk) disable iff (rst)
    scan_stage != 2'd3)
    else $error("scan stage out of rotation");

  a_save_value: assert property (@(posedge clk) disable iff (rst)
    res_v && res_save |-> res_save_val == res_count && res_save_val == saved_count)
    else $error("saved value does not match count");

  a_enable_only_scan: assert property (@(posedge clk) disable iff (rst)
    advance && in_kind != KIND_SCAN |=> res_disp.digit_enable_n == EN_NONE)
    else $error("digit driven on a non-scan item");

endmodule

`default_nettype wire
